@@ src/assert_macros.svh @@
// assertion macros shared by the allocator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fpba_pkg.sv @@
// constants and codes for the fit policy block allocator
// no dependencies
package fpba_pkg;

  // field widths of the stream items
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned AMOUNT_W  = 16;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

  // fit policy codes
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NONE  = 2'd3;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] FIT_POLICY_RST    = FIT_FIRST;
  localparam logic [4:0] BLOCKS_IN_USE_RST = 5'd16;

endpackage

@@ src/fpba_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module fpba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fit_policy_block_allocator.sv @@
// fit policy block allocator top level: free size table, scan sequencer, output register
// depends on fpba_pkg, fpba_ram and assert_macros.svh
//
// The block keeps the remaining free size of up to MAX_BLOCKS memory blocks in a
// small ram. A load item (tuser 0) writes one block's size and gives no result;
// a load to a slot at or above MAX_BLOCKS is dropped. An allocate item (tuser 1)
// asks for a size and gives exactly one result item: the granted block index and
// its size after subtraction, or tuser 0 with zero data when nothing fits. Under
// first fit the lowest fitting block wins, under best fit the smallest, under
// worst fit the largest, with ties going to the higher index; policy code 3
// never grants. Blocks 0 up to blocks_in_use-1 are searched (capped at
// MAX_BLOCKS); a block must be loaded before it is searched. Sequencing: an
// allocate walks the table one entry per cycle through the single ram read
// port and one shared compare unit; the input stays held off through the scan
// and the done step, which writes back and loads the result register. An
// allocate that searches nothing goes straight to the done step, which waits
// while an earlier result still sits in the result register. The result
// register lets the next item in while a result waits, but a second result
// cannot leave the sequencer until the first one is taken. Configuration may
// only be written while idle.
`include "assert_macros.svh"

module fit_policy_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_data_i,

  // request items
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [3:0] block_slot, [19:4] amount, [23:20] zero
  input  logic [fpba_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [0] operation
  input  logic                             s_axis_tuser_i,

  // result items
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [3:0] granted_block, [19:4] space_left, [23:20] zero
  output logic [fpba_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // [0] allocated
  output logic                             m_axis_tuser_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // configuration registers
  logic [1:0] fit_policy_q, fit_policy_d;
  logic [4:0] blocks_in_use_q, blocks_in_use_d;

  // sequencer control
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;   // next entry to read
  logic [CNT_W-1:0] count_q, count_d;     // entries to search for this item
  logic             chk_vld_q, chk_vld_d; // ram data is back for chk_idx
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             found_q, found_d;

  // item payload and running pick
  logic [1:0]           policy_q, policy_d;
  logic [SIZE_BITS-1:0] amt_q, amt_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic [IDX_W-1:0]     pick_q, pick_d;

  // result register
  logic                             m_valid_q, m_valid_d;
  logic                             m_alloc_q, m_alloc_d;
  logic [fpba_pkg::SLOT_W-1:0]      m_block_q, m_block_d;
  logic [fpba_pkg::AMOUNT_W-1:0]    m_space_q, m_space_d;

  // request fields
  logic                          in_op;
  logic [fpba_pkg::SLOT_W-1:0]   in_slot;
  logic [fpba_pkg::AMOUNT_W-1:0] in_amount;
  logic [SIZE_BITS-1:0]          in_amt;
  logic [IDX_W+fpba_pkg::SLOT_W-1:0] slot_ext;
  logic                          in_fire;
  logic                          cfg_fire;
  logic [CNT_W-1:0]              search_cnt;

  // ram ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [SIZE_BITS-1:0] ram_rdata;

  // shared compare unit
  logic fits;
  logic better;
  logic take;
  logic out_free;
  logic [SIZE_BITS-1:0] remain;

  assign in_op     = s_axis_tuser_i;
  assign in_slot   = s_axis_tdata_i[fpba_pkg::SLOT_W-1:0];
  assign in_amount = s_axis_tdata_i[fpba_pkg::SLOT_W +: fpba_pkg::AMOUNT_W];
  assign in_amt    = SIZE_BITS'(in_amount);
  assign slot_ext  = (IDX_W + fpba_pkg::SLOT_W)'(in_slot);

  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // number of searched blocks, saturated to the table depth
  always_comb begin
    if (32'(blocks_in_use_q) > 32'(MAX_BLOCKS)) begin
      search_cnt = CNT_W'(MAX_BLOCKS);
    end else begin
      search_cnt = CNT_W'(blocks_in_use_q);
    end
  end

  // the one comparator pair that every scan step goes through
  assign fits = (amt_q <= ram_rdata);
  always_comb begin
    case (policy_q)
      fpba_pkg::FIT_BEST:  better = (ram_rdata <= best_q);
      fpba_pkg::FIT_WORST: better = (ram_rdata >= best_q);
      default:             better = 1'b0;
    endcase
  end
  assign take   = chk_vld_q && fits && (!found_q || better);
  assign remain = best_q - amt_q;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign ram_re   = (state_q == ST_SCAN) && (rd_idx_q < count_q);

  always_comb begin
    fit_policy_d    = fit_policy_q;
    blocks_in_use_d = blocks_in_use_q;
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    count_d   = count_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    found_d   = found_q;
    policy_d  = policy_q;
    amt_d     = amt_q;
    best_d    = best_q;
    pick_d    = pick_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_alloc_d = m_alloc_q;
    m_block_d = m_block_q;
    m_space_d = m_space_q;
    ram_we    = 1'b0;
    ram_waddr = pick_q;
    ram_wdata = remain;

    if (cfg_fire) begin
      case (cfg_index_i)
        fpba_pkg::REG_FIT_POLICY:    fit_policy_d    = cfg_data_i[1:0];
        fpba_pkg::REG_BLOCKS_IN_USE: blocks_in_use_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == fpba_pkg::OP_LOAD) begin
            // loads beyond the table are dropped
            ram_we    = (32'(in_slot) < 32'(MAX_BLOCKS));
            ram_waddr = slot_ext[IDX_W-1:0];
            ram_wdata = in_amt;
          end else begin
            policy_d = fit_policy_q;
            amt_d    = in_amt;
            count_d  = search_cnt;
            rd_idx_d = '0;
            found_d  = 1'b0;
            if ((fit_policy_q == fpba_pkg::FIT_NONE) || (search_cnt == '0)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (ram_re) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[IDX_W-1:0];
        end
        if (take) begin
          found_d = 1'b1;
          pick_d  = chk_idx_q;
          best_d  = ram_rdata;
        end else if (!ram_re && !chk_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_alloc_d = found_q;
          if (found_q) begin
            ram_we    = 1'b1;
            m_block_d = fpba_pkg::SLOT_W'(pick_q);
            m_space_d = fpba_pkg::AMOUNT_W'(remain);
          end else begin
            m_block_d = '0;
            m_space_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q    <= fpba_pkg::FIT_POLICY_RST;
      blocks_in_use_q <= fpba_pkg::BLOCKS_IN_USE_RST;
      state_q         <= ST_IDLE;
      rd_idx_q        <= '0;
      count_q         <= '0;
      chk_vld_q       <= 1'b0;
      found_q         <= 1'b0;
      m_valid_q       <= 1'b0;
    end else begin
      fit_policy_q    <= fit_policy_d;
      blocks_in_use_q <= blocks_in_use_d;
      state_q         <= state_d;
      rd_idx_q        <= rd_idx_d;
      count_q         <= count_d;
      chk_vld_q       <= chk_vld_d;
      found_q         <= found_d;
      m_valid_q       <= m_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    policy_q  <= policy_d;
    amt_q     <= amt_d;
    best_q    <= best_d;
    pick_q    <= pick_d;
    m_alloc_q <= m_alloc_d;
    m_block_q <= m_block_d;
    m_space_q <= m_space_d;
  end

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_free_space (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_alloc_q;
  assign m_axis_tdata_o  = {
    (fpba_pkg::M_TDATA_W - fpba_pkg::AMOUNT_W - fpba_pkg::SLOT_W)'(0),
    m_space_q,
    m_block_q
  };

  // the read pointer never runs past the searched range
  `ASSERT_HOLDS(a_rd_idx_range, clk_i, rst_ni,
    (state_q != ST_SCAN) || (rd_idx_q <= count_q), "scan read pointer past block count")
  // a compare step only happens while scanning
  `ASSERT_HOLDS(a_chk_in_scan, clk_i, rst_ni,
    !chk_vld_q || (state_q == ST_SCAN), "compare step outside of scan")
  // a pick always lies inside the searched range
  `ASSERT_HOLDS(a_pick_range, clk_i, rst_ni,
    !found_q || (state_q == ST_IDLE) || (32'(pick_q) < 32'(count_q)),
    "picked block outside searched range")
  // a finished search hands its result over and frees the input
  `ASSERT_NEXT(a_done_release, clk_i, rst_ni,
    (state_q == ST_DONE) && out_free, m_valid_q && (state_q == ST_IDLE),
    "finished search did not deliver its result")

endmodule

@@ verif/fit_policy_block_allocator_checker.sv @@
// checker for the fit policy block allocator: watches the config, request and result streams
// keeps its own free size table, predicts each grant and compares it with the result items
// depends on fpba_pkg
module fit_policy_block_allocator_checker
  import fpba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  // [3:0] block_slot, [19:4] amount, [23:20] zero
  input  logic [S_TDATA_W-1:0]  s_tdata_i,
  // [0] operation
  input  logic                  s_tuser_i,

  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // [3:0] granted_block, [19:4] space_left, [23:20] zero
  input  logic [M_TDATA_W-1:0]  m_tdata_i,
  // [0] allocated
  input  logic                  m_tuser_i,

  output int                    fail_count_o,
  output int                    pending_o,
  output int                    granted_o,
  output int                    refused_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                allocated;
    logic [SLOT_W-1:0]   block;
    logic [AMOUNT_W-1:0] space;
  } grant_t;

  logic [AMOUNT_W-1:0] free_left [MAX_BLOCKS];
  logic [1:0]          policy_q;
  logic [4:0]          blocks_q;
  grant_t              grants_due [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    granted_o    = 0;
    refused_o    = 0;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // scan the searched blocks under the current policy, later index wins a tie
  function automatic grant_t serve_request(input logic [AMOUNT_W-1:0] want);
    grant_t g;
    int     span;
    int     pick;
    bit     hit;
    g    = '0;
    pick = 0;
    hit  = 1'b0;
    span = (int'(blocks_q) > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_q);
    if (policy_q != FIT_NONE) begin
      for (int i = 0; i < span; i++) begin
        if (want <= free_left[i]) begin
          if (!hit) begin
            hit  = 1'b1;
            pick = i;
            if (policy_q == FIT_FIRST) break;
          end else if (policy_q == FIT_BEST && free_left[i] <= free_left[pick]) begin
            pick = i;
          end else if (policy_q == FIT_WORST && free_left[i] >= free_left[pick]) begin
            pick = i;
          end
        end
      end
    end
    if (hit) begin
      free_left[pick] = free_left[pick] - want;
      g.allocated     = 1'b1;
      g.block         = SLOT_W'(pick);
      g.space         = free_left[pick];
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t seen;
    grant_t due;
    if (!rst_ni) begin
      policy_q = FIT_POLICY_RST;
      blocks_q = BLOCKS_IN_USE_RST;
      foreach (free_left[i]) free_left[i] = '0;
      grants_due.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FIT_POLICY:    policy_q = cfg_data_i[1:0];
          REG_BLOCKS_IN_USE: blocks_q = cfg_data_i;
          default: ;
        endcase
      end
      // results first, so a stray one never meets the item accepted on this edge
      if (m_tvalid_i && m_tready_i) begin
        seen.allocated = m_tuser_i;
        seen.block     = m_tdata_i[SLOT_W-1:0];
        seen.space     = m_tdata_i[SLOT_W +: AMOUNT_W];
        if (grants_due.size() == 0) begin
          flag_mismatch("result with no request waiting", int'(seen), 0);
        end else begin
          due = grants_due.pop_front();
          if (seen.allocated != due.allocated)
            flag_mismatch("allocated", seen.allocated, due.allocated);
          if (seen.block != due.block)
            flag_mismatch("granted_block", seen.block, due.block);
          if (seen.space != due.space)
            flag_mismatch("space_left", seen.space, due.space);
          if (due.allocated) granted_o++;
          else refused_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == OP_LOAD) begin
          if (int'(s_tdata_i[SLOT_W-1:0]) < MAX_BLOCKS)
            free_left[s_tdata_i[SLOT_W-1:0]] = s_tdata_i[SLOT_W +: AMOUNT_W];
        end else begin
          grants_due.push_back(serve_request(s_tdata_i[SLOT_W +: AMOUNT_W]));
        end
      end
      pending_o = grants_due.size();
    end
  end

endmodule

@@ verif/fit_policy_block_allocator_tb.sv @@
// top of the fit policy block allocator testbench: clock, reset, stimulus and verdict
// drives loads, allocations and policy changes; the checker beside the block does the scoring
// depends on fpba_pkg, fit_policy_block_allocator and fit_policy_block_allocator_checker
module fit_policy_block_allocator_tb;
  import fpba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS   = 16;
  localparam int CLK_PERIOD   = 12;
  // an allocate scans up to sixteen entries, so the drain covers a full scan
  localparam int DRAIN_CYCLES = 40;
  // long receiver hold-off, far longer than the block can buffer
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASES       = 13;
  localparam int PAD_W        = S_TDATA_W - SLOT_W - AMOUNT_W;

  // register indexes with no register behind them, written once to show they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_valid;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic                  s_valid;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_data;
  logic                  s_user;

  logic                  m_axis_tvalid_o;
  logic                  m_ready;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  int fails;
  int pending;
  int granted;
  int refused;

  // shared between the request driver and the result sink
  bit steady    = 1'b0;  // no gaps and no stalls on either side
  bit hold_sink = 1'b0;  // ask the sink for one long hold-off

  int loads_sent  = 0;
  int allocs_sent = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  fit_policy_block_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SIZE_BITS (16)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  fit_policy_block_allocator_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_axis_tready_o),
    .s_tdata_i   (s_data),
    .s_tuser_i   (s_user),
    .m_tvalid_i  (m_axis_tvalid_o),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_axis_tdata_o),
    .m_tuser_i   (m_axis_tuser_o),
    .fail_count_o(fails),
    .pending_o   (pending),
    .granted_o   (granted),
    .refused_o   (refused)
  );

  // offer one request item, after a random gap unless steady, return on the falling edge after it is taken
  task automatic offer(input logic op, input logic [SLOT_W-1:0] slot,
                       input logic [AMOUNT_W-1:0] amount);
    int gap;
    int r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {{PAD_W{1'b0}}, amount, slot};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (op == OP_ALLOC) allocs_sent++;
    else loads_sent++;
  endtask

  // one register write; valid drops for a cycle so back-to-back writes never overlap
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering, let every grant come back, then cover a load still in flight
  task automatic settle();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // result sink: short stalls mostly, a few long ones, one very long hold on request
  initial begin
    int r;
    int n;
    m_ready <= 1'b0;
    repeat (4) @(negedge clk_i);
    forever begin
      if (hold_sink) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_sink = 1'b0;
      end else if (steady) begin
        m_ready <= 1'b1;
        @(negedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          m_ready <= 1'b1;
          n = $urandom_range(1, 12);
        end else if (r < 95) begin
          m_ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          m_ready <= 1'b0;
          n = $urandom_range(15, 60);
        end
        repeat (n) @(negedge clk_i);
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d grants still pending", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [1:0]          ph_policy [PHASES];
    int                  ph_len    [PHASES];
    logic [1:0]          policy;
    logic [4:0]          blocks;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
    int                  span;
    int                  r;
    int                  pick;

    ph_policy = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FIRST, FIT_BEST, FIT_WORST, FIT_NONE,
                  FIT_BEST, FIT_WORST, FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FIRST};
    ph_len    = '{150, 150, 150, 60, 150, 150, 30, 30, 120, 120, 150, 150, 220};

    // every block input known from time zero
    rst_ni    <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FIT_POLICY;
    cfg_data  <= '0;
    s_valid   <= 1'b0;
    s_user    <= OP_LOAD;
    s_data    <= '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: fill the whole table first so no search ever meets an unloaded entry;
    // sizes hold zero, the maximum, an equal pair and a rising ramp
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (i == 0) amount = '0;
      else if (i == 1) amount = '1;
      else if (i < 4) amount = 16'd100;
      else amount = AMOUNT_W'(200 + i * 50);
      offer(OP_LOAD, SLOT_W'(i), amount);
    end
    // first fit out of reset: zero request on a zero block, full-size grant, refusal, small grant
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), '0);
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), '1);
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), '1);
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd100);
    settle();
    // best fit, then a zero request where several searched blocks tie at zero size
    set_reg(REG_FIT_POLICY, {3'b000, FIT_BEST});
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd100);
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), '0);
    settle();
    set_reg(REG_FIT_POLICY, {3'b000, FIT_WORST});
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd1);
    settle();
    // unused policy code never grants
    set_reg(REG_FIT_POLICY, {3'b000, FIT_NONE});
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), '0);
    settle();
    // empty search range, then a count above the table size, then a single block
    set_reg(REG_FIT_POLICY, {3'b000, FIT_FIRST});
    set_reg(REG_BLOCKS_IN_USE, 5'd0);
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), '0);
    settle();
    set_reg(REG_BLOCKS_IN_USE, 5'd31);
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd900);
    settle();
    set_reg(REG_BLOCKS_IN_USE, 5'd1);
    offer(OP_ALLOC, SLOT_W'($urandom_range(0, 15)), '0);
    settle();

    // random phases: each one a policy and a search range, written while idle
    for (int ph = 0; ph < PHASES; ph++) begin
      policy = ph_policy[ph];
      case (ph)
        3:       blocks = 5'd1;
        4, 5:    blocks = 5'($urandom_range(2, 15));
        7:       blocks = 5'd0;
        8:       blocks = 5'd31;
        9:       blocks = 5'($urandom_range(17, 31));
        12:      blocks = 5'($urandom_range(1, 16));
        default: blocks = 5'd16;
      endcase
      // the unused indexes take a write once, on the phase with the unused policy
      if (policy == FIT_NONE) begin
        set_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 31)));
        set_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 31)));
      end
      // upper data bits of the policy write are don't-care, toggle them anyway
      set_reg(REG_FIT_POLICY, {3'($urandom_range(0, 7)), policy});
      set_reg(REG_BLOCKS_IN_USE, blocks);
      span = (int'(blocks) > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks);

      // one phase with no idling at all, one that starts under a long sink hold-off
      steady = (ph == 10);
      if (ph == 11) hold_sink = 1'b1;

      for (int n = 0; n < ph_len[ph]; n++) begin
        r    = $urandom_range(0, 99);
        slot = SLOT_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (r < 45) begin
          // refills mostly land in the searched range; power-of-two sizes make ties
          if (span > 0 && $urandom_range(0, 9) < 7) slot = SLOT_W'($urandom_range(0, span - 1));
          if (pick < 25) amount = 16'd64 << $urandom_range(0, 4);
          else if (pick < 35) amount = '0;
          else if (pick < 40) amount = '1;
          else if (pick < 70) amount = AMOUNT_W'($urandom_range(0, 4095));
          else amount = AMOUNT_W'($urandom_range(0, 65535));
          offer(OP_LOAD, slot, amount);
        end else begin
          // requests lean small so grants stay frequent; slot field is don't-care here
          if (pick < 10) amount = '0;
          else if (pick < 40) amount = AMOUNT_W'($urandom_range(1, 64));
          else if (pick < 65) amount = 16'd64 << $urandom_range(0, 4);
          else if (pick < 90) amount = AMOUNT_W'($urandom_range(0, 4095));
          else if (pick < 95) amount = '1;
          else amount = AMOUNT_W'($urandom_range(0, 65535));
          offer(OP_ALLOC, slot, amount);
        end
      end
      settle();
      steady = 1'b0;
    end

    $display("run covered %0d loads and %0d allocate requests across %0d policy phases",
             loads_sent, allocs_sent, PHASES);
    $display("allocator granted %0d requests and refused %0d", granted, refused);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches seen", fails);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/fpba_pkg.sv
src/fpba_ram.sv
src/fit_policy_block_allocator.sv
verif/fit_policy_block_allocator_checker.sv
verif/fit_policy_block_allocator_tb.sv
